[hdl/ordered_key_list_engine_unit_defines.svh]
// Assertion macros shared by the ordered key list checker.
// Depends on a clk and an active-low rst_n in the scope that uses them.
`ifndef ORDERED_KEY_LIST_ENGINE_UNIT_DEFINES_SVH
`define ORDERED_KEY_LIST_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define OKL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered key list check failed");

// Next-cycle implication, disabled during reset.
`define OKL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered key list check failed");

`endif

[hdl/okl_pkg.sv]
// Shared types and constants of the ordered key list engine.
// No dependencies; imported by every module of the block except okl_ram.
package okl_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = 32;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_DUMP   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [KEY_W-1:0] key;
    } okl_req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [KEY_W-1:0] key_out;
        logic                    last;
    } okl_rsp_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [KEY_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } okl_mem_req_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_DUMP
    } okl_state_t;

endpackage

[hdl/okl_ram.sv]
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module okl_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/okl_ctrl.sv]
// Sequencer of the ordered key list: insert, search and compact, dump.
// Depends on okl_pkg; drives the entry RAM through an okl_mem_req_t.
module okl_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  okl_pkg::okl_req_t           req,
    output logic                        busy,
    output logic                        done,
    output okl_pkg::okl_rsp_t           rsp,
    output okl_pkg::okl_mem_req_t       mem,
    input  logic [okl_pkg::KEY_W-1:0]   rdata
);
    import okl_pkg::*;

    okl_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] cmp_reg, cmp_next;
    logic             vld_reg, vld_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic             done_reg, done_next;
    okl_rsp_t         rsp_reg, rsp_next;
    logic [CNT_W-1:0] last_idx;
    logic [CNT_W-1:0] wr_idx;
    logic             finish;

    assign last_idx = count_reg - CNT_W'(1);
    assign wr_idx   = cmp_reg - CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            rd_idx_reg <= '0;
            cmp_reg    <= '0;
            vld_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
            cmp_reg    <= cmp_next;
            vld_reg    <= vld_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        cmp_next    = cmp_reg;
        vld_next    = 1'b0;
        key_next    = key_reg;
        done_next   = 1'b0;
        rsp_next    = '0;
        mem         = '0;
        mem.raddr   = rd_idx_reg[IDX_W-1:0];
        finish      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next    = req.key;
                    rd_idx_next = '0;
                    case (req.action)
                        ACT_INSERT:
                        begin
                            done_next     = 1'b1;
                            rsp_next.last = 1'b1;
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                mem.we          = 1'b1;
                                mem.waddr       = count_reg[IDX_W-1:0];
                                mem.wdata       = req.key;
                                count_next      = count_reg + CNT_W'(1);
                                rsp_next.status = ST_OK;
                            end
                        end
                        ACT_REMOVE, ACT_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next       = 1'b1;
                                rsp_next.status = ST_EMPTY;
                                rsp_next.last   = 1'b1;
                            end
                            else if (req.action == ACT_REMOVE)
                            begin
                                state_next = S_SEARCH;
                            end
                            else
                            begin
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            // drop undefined action codes
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (vld_reg)
                begin
                    if (rdata == key_reg)
                    begin
                        if (cmp_reg == last_idx)
                        begin
                            finish           = 1'b1;
                            count_next       = last_idx;
                            done_next        = 1'b1;
                            rsp_next.status  = ST_OK;
                            rsp_next.key_out = key_reg;
                            rsp_next.last    = 1'b1;
                        end
                        else
                        begin
                            state_next = S_SHIFT;
                        end
                    end
                    else if (cmp_reg == last_idx)
                    begin
                        finish          = 1'b1;
                        done_next       = 1'b1;
                        rsp_next.status = ST_NOT_FOUND;
                        rsp_next.last   = 1'b1;
                    end
                end
            end
            S_SHIFT:
            begin
                // move each later entry down one place
                if (vld_reg)
                begin
                    mem.we    = 1'b1;
                    mem.waddr = wr_idx[IDX_W-1:0];
                    mem.wdata = rdata;
                    if (cmp_reg == last_idx)
                    begin
                        finish           = 1'b1;
                        count_next       = last_idx;
                        done_next        = 1'b1;
                        rsp_next.status  = ST_OK;
                        rsp_next.key_out = key_reg;
                        rsp_next.last    = 1'b1;
                    end
                end
            end
            S_DUMP:
            begin
                if (vld_reg)
                begin
                    done_next        = 1'b1;
                    rsp_next.status  = ST_OK;
                    rsp_next.key_out = rdata;
                    rsp_next.last    = (cmp_reg == last_idx);
                    finish           = (cmp_reg == last_idx);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // advance the read stream one entry a cycle
        if (state_reg != S_IDLE && rd_idx_reg < count_reg)
        begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
            cmp_next    = rd_idx_reg;
            vld_next    = !finish;
        end

        if (finish)
        begin
            state_next = S_IDLE;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

[hdl/ordered_key_list_engine_unit.sv]
// Ordered key list engine: insert at tail, remove first match, dump in order.
// Insert, and a remove or dump on an empty list, gives its result in the cycle after start.
// Remove gives its result once every entry is read, one read per entry; shifts overlap.
// Dump emits one result a cycle; no stall possible.
// Insert takes one request a cycle; remove and dump hold busy until their last result.
// Reset empties the list at once; entry RAM contents stay undefined, no clearing pass.
module ordered_key_list_engine_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  okl_pkg::okl_req_t req,
    output logic              busy,
    output logic              done,
    output okl_pkg::okl_rsp_t rsp
);
    import okl_pkg::*;

    okl_mem_req_t     mem;
    logic [KEY_W-1:0] rdata;

    okl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp),
        .mem   (mem),
        .rdata (rdata)
    );

    okl_ram #(
        .DATA_W (KEY_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .raddr (mem.raddr),
        .rdata (rdata)
    );

endmodule

[hdl/okl_checker.sv]
// Port-level checks of the ordered key list engine, bound to the top level.
// Depends on okl_pkg and ordered_key_list_engine_unit_defines.svh.
`include "ordered_key_list_engine_unit_defines.svh"

module okl_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input okl_pkg::okl_req_t req,
    input logic              busy,
    input logic              done,
    input okl_pkg::okl_rsp_t rsp
);
    import okl_pkg::*;

    `OKL_ASSERT_NXT(a_insert_one_cycle, start && !busy && req.action == ACT_INSERT, done && rsp.last)
    `OKL_ASSERT_NXT(a_dump_no_gap, done && !rsp.last, done)
    `OKL_ASSERT_IMP(a_error_is_single, done && rsp.status != ST_OK, rsp.last && rsp.key_out == '0)
    `OKL_ASSERT_IMP(a_last_frees, done && rsp.last, !busy)

endmodule

bind ordered_key_list_engine_unit okl_checker u_okl_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .req   (req),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
